[rtl/slcd_pkg.sv]
package slcd_pkg;

  // sync pattern and header size
  localparam logic [7:0] SyncFirst  = 8'h55;
  localparam logic [7:0] SyncSecond = 8'hAA;
  localparam int unsigned HdrLen    = 5;

  // step commands from the controller to the datapath
  typedef struct packed {
    logic clear;    // restart: drop window and partial frame first
    logic hunt;     // item taken while hunting for a header
    logic payload;  // item taken as a payload byte
    logic check;    // item taken as the checksum byte
  } slcd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic hdr_done;  // this byte completes a valid header
    logic len_zero;  // the completed header has an empty payload
    logic rem_last;  // current payload byte is the last one
  } slcd_status_t;

endpackage

[rtl/slcd_if.sv]
// input channel: one received byte per item
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       restart;

  modport source (output valid, output rx_byte, output restart, input ready);
  modport sink (input valid, input rx_byte, input restart, output ready);
endinterface

// output channel: one payload or closing result per item
interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] command;
  logic [7:0] payload_byte;
  logic [7:0] byte_index;
  logic       frame_end;
  logic       frame_good;

  modport source (output valid, output command, output payload_byte, output byte_index,
                  output frame_end, output frame_good, input ready);
  modport sink (input valid, input command, input payload_byte, input byte_index,
                input frame_end, input frame_good, output ready);
endinterface

[rtl/slcd_ctrl.sv]
module slcd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  restart_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  slcd_pkg::slcd_status_t status_i,
  output slcd_pkg::slcd_cmd_t    cmd_o
);

  localparam logic [1:0] StHunt    = 2'd0;
  localparam logic [1:0] StPayload = 2'd1;
  localparam logic [1:0] StCheck   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [1:0] state_eff;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  // take a new byte whenever the output register is free or being emptied
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // restart forces hunting before the byte is looked at
  assign state_eff = restart_i ? StHunt : state_q;

  // phase sequencing and step commands
  always_comb begin
    state_d       = state_q;
    cmd_o.clear   = accept && restart_i;
    cmd_o.hunt    = 1'b0;
    cmd_o.payload = 1'b0;
    cmd_o.check   = 1'b0;
    unique case (state_eff)
      StPayload: begin
        cmd_o.payload = accept;
        if (accept && status_i.rem_last) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        cmd_o.check = accept;
        if (accept) begin
          state_d = StHunt;
        end
      end
      default: begin
        // hunting, also the unused code
        cmd_o.hunt = accept;
        if (accept) begin
          if (status_i.hdr_done) begin
            state_d = status_i.len_zero ? StCheck : StPayload;
          end else begin
            state_d = StHunt;
          end
        end
      end
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.payload || cmd_o.check) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StHunt;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/slcd_dp.sv]
module slcd_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            rx_byte_i,
  input  slcd_pkg::slcd_cmd_t    cmd_i,
  output slcd_pkg::slcd_status_t status_o,
  output logic [7:0]            command_o,
  output logic [7:0]            payload_byte_o,
  output logic [7:0]            byte_index_o,
  output logic                  frame_end_o,
  output logic                  frame_good_o
);

  localparam int unsigned WinBits = slcd_pkg::HdrLen * 8;

  // header window and frame state
  logic [slcd_pkg::HdrLen-1:0][7:0] win_q;
  logic [2:0]                      fill_q, fill_d;
  logic [7:0]                      cmd_q, rem_q, sum_q, pos_q;

  // output register
  logic [7:0] out_cmd_q, out_byte_q, out_idx_q;
  logic       out_end_q, out_good_q;

  logic [2:0]                      fill_eff;
  logic [2:0]                      cnt;
  logic [slcd_pkg::HdrLen-1:0][7:0] wcat;
  logic [slcd_pkg::HdrLen:0]        ok;
  logic [2:0]                      sel;
  logic [WinBits-1:0]              shifted;

  assign fill_eff = cmd_i.clear ? 3'd0 : fill_q;
  assign cnt      = fill_eff + 3'd1;

  // window with the new byte appended
  always_comb begin
    for (int i = 0; i < slcd_pkg::HdrLen; i++) begin
      if (3'(i) < fill_eff) begin
        wcat[i] = win_q[i];
      end else if (3'(i) == fill_eff) begin
        wcat[i] = rx_byte_i;
      end else begin
        wcat[i] = 8'h00;
      end
    end
  end

  // a suffix of the window is kept if it is empty or a valid partial header
  always_comb begin
    ok[slcd_pkg::HdrLen] = 1'b1;
    for (int s = 0; s < slcd_pkg::HdrLen; s++) begin
      ok[s] = (3'(s) >= cnt) || (wcat[s] == slcd_pkg::SyncFirst);
      if (s + 1 < slcd_pkg::HdrLen) begin
        ok[s] = ok[s] && ((3'(s + 1) >= cnt) || (wcat[s + 1] == slcd_pkg::SyncSecond));
      end
      if (s == 0) begin
        ok[s] = ok[s] && ((cnt != 3'(slcd_pkg::HdrLen)) || (wcat[3] == ~wcat[4]));
      end
    end
  end

  // drop count: first suffix that survives
  always_comb begin
    sel = 3'(slcd_pkg::HdrLen);
    for (int s = slcd_pkg::HdrLen - 1; s >= 0; s--) begin
      if (ok[s]) begin
        sel = 3'(s);
      end
    end
  end

  assign shifted = wcat >> {sel, 3'b000};
  assign fill_d  = cnt - sel;

  assign status_o.hdr_done = (cnt == 3'(slcd_pkg::HdrLen)) && (sel == 3'd0);
  assign status_o.len_zero = (wcat[3] == 8'h00);
  assign status_o.rem_last = (rem_q == 8'd1);

  // window fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 3'd0;
    end else if (cmd_i.hunt) begin
      fill_q <= status_o.hdr_done ? 3'd0 : fill_d;
    end else if (cmd_i.check || cmd_i.clear) begin
      fill_q <= 3'd0;
    end
  end

  // window bytes and frame counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.hunt) begin
      win_q <= shifted;
      if (status_o.hdr_done) begin
        cmd_q <= wcat[2];
        rem_q <= wcat[3];
        sum_q <= wcat[2] + wcat[3] + wcat[4];
        pos_q <= 8'd0;
      end
    end else if (cmd_i.payload) begin
      sum_q <= sum_q + rx_byte_i;
      pos_q <= pos_q + 8'd1;
      rem_q <= rem_q - 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.payload) begin
      out_cmd_q  <= cmd_q;
      out_byte_q <= rx_byte_i;
      out_idx_q  <= pos_q;
      out_end_q  <= 1'b0;
      out_good_q <= 1'b0;
    end else if (cmd_i.check) begin
      out_cmd_q  <= cmd_q;
      out_byte_q <= 8'h00;
      out_idx_q  <= pos_q;
      out_end_q  <= 1'b1;
      out_good_q <= (sum_q == rx_byte_i);
    end
  end

  assign command_o      = out_cmd_q;
  assign payload_byte_o = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign frame_end_o    = out_end_q;
  assign frame_good_o   = out_good_q;

endmodule

[rtl/sync_length_checksum_deframer_top.sv]
// Byte-stream deframer for frames 0x55 0xAA CMD LEN ~LEN PAYLOAD CHK. One
// received byte is taken per item and handled when it is accepted: header
// bytes are collected in a five-byte window that is rescanned in one step
// on a bad sync or length complement, each payload byte gives one result
// with its command and index, and the checksum byte gives a closing result
// marked frame_end with a good/bad verdict (byte_index then holds the
// payload length). The receiver discards a frame whose verdict is bad.
// A byte is accepted every cycle; ready drops only while a result sits in
// the output register and the sink does not take it. restart clears any
// partial frame before its byte is looked at.
module sync_length_checksum_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  slcd_in_if.sink     rx_i,
  slcd_out_if.source  res_o
);

  slcd_pkg::slcd_cmd_t    cmd;
  slcd_pkg::slcd_status_t status;

  // phase control and handshake
  slcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rx_i.valid),
    .restart_i   (rx_i.restart),
    .in_ready_o  (rx_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // window, counters and result register
  slcd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_byte_i      (rx_i.rx_byte),
    .cmd_i          (cmd),
    .status_o       (status),
    .command_o      (res_o.command),
    .payload_byte_o (res_o.payload_byte),
    .byte_index_o   (res_o.byte_index),
    .frame_end_o    (res_o.frame_end),
    .frame_good_o   (res_o.frame_good)
  );

endmodule

[verif/sync_length_checksum_deframer_top_tb.sv]
`timescale 1ns / 100ps

module sync_length_checksum_deframer_top_tb;

  localparam int unsigned TotalBytes       = 1050;
  localparam int unsigned StallLimit       = 2000;
  localparam int unsigned MaxMismatchLines = 30;
  localparam int unsigned HoldCycles       = 64;
  localparam int unsigned WholeFrame       = 300;

  typedef enum logic [1:0] {
    HUNTING,
    IN_PAYLOAD,
    AT_CHECKSUM
  } deframe_phase_e;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic       frame_end;
    logic       frame_good;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  slcd_in_if  rx_if ();
  slcd_out_if res_if ();

  sync_length_checksum_deframer_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  // deframer state as seen by the predictor
  logic [7:0]     hdr_win [slcd_pkg::HdrLen];
  logic [2:0]     win_fill;
  deframe_phase_e phase;
  logic [7:0]     bytes_left;
  logic [7:0]     frame_sum;
  logic [7:0]     frame_cmd;
  logic [7:0]     payload_pos;

  frame_result_t expected_results [$];

  int unsigned error_count  = 0;
  int unsigned sent_count   = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_on      = 1'b0;

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_deframer();
    foreach (hdr_win[i]) hdr_win[i] = 8'h00;
    win_fill    = '0;
    phase       = HUNTING;
    bytes_left  = 8'h00;
    frame_sum   = 8'h00;
    frame_cmd   = 8'h00;
    payload_pos = 8'h00;
  endfunction

  // shift the header window down by one byte
  function automatic void drop_oldest_byte();
    for (int i = 0; i < slcd_pkg::HdrLen - 1; i++) hdr_win[i] = hdr_win[i + 1];
    hdr_win[slcd_pkg::HdrLen - 1] = 8'h00;
    if (win_fill != 0) win_fill--;
  endfunction

  function automatic bit header_broken();
    if (win_fill >= 1 && hdr_win[0] != slcd_pkg::SyncFirst) return 1'b1;
    if (win_fill >= 2 && hdr_win[1] != slcd_pkg::SyncSecond) return 1'b1;
    if (win_fill >= slcd_pkg::HdrLen && hdr_win[3] != ~hdr_win[4]) return 1'b1;
    return 1'b0;
  endfunction

  // advance the predictor by one received byte, queue any result it gives
  function automatic void deframe_byte(input logic [7:0] b, input logic clr);
    frame_result_t res;
    if (clr) clear_deframer();
    case (phase)
      IN_PAYLOAD: begin
        res = '{frame_cmd, b, payload_pos, 1'b0, 1'b0};
        expected_results.push_back(res);
        frame_sum   = frame_sum + b;
        payload_pos = payload_pos + 8'd1;
        bytes_left  = bytes_left - 8'd1;
        if (bytes_left == 0) phase = AT_CHECKSUM;
      end
      AT_CHECKSUM: begin
        res = '{frame_cmd, 8'h00, payload_pos, 1'b1, frame_sum == b};
        expected_results.push_back(res);
        clear_deframer();
      end
      default: begin
        phase = HUNTING;
        if (win_fill >= slcd_pkg::HdrLen) drop_oldest_byte();
        hdr_win[win_fill] = b;
        win_fill++;
        // rescan until the window is empty or holds a plausible header
        while (win_fill != 0 && header_broken()) drop_oldest_byte();
        if (win_fill == slcd_pkg::HdrLen) begin
          frame_cmd   = hdr_win[2];
          bytes_left  = hdr_win[3];
          frame_sum   = hdr_win[2] + hdr_win[3] + hdr_win[4];
          payload_pos = 8'h00;
          phase       = (bytes_left == 0) ? AT_CHECKSUM : IN_PAYLOAD;
          foreach (hdr_win[i]) hdr_win[i] = 8'h00;
          win_fill = '0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (error_count < MaxMismatchLines)
      $display("%0t ns: %s got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, command", res_if.command, 8'h00);
      end else begin
        want = expected_results.pop_front();
        if (res_if.command !== want.command)
          report_mismatch("command", res_if.command, want.command);
        if (res_if.payload_byte !== want.payload_byte)
          report_mismatch("payload_byte", res_if.payload_byte, want.payload_byte);
        if (res_if.byte_index !== want.byte_index)
          report_mismatch("byte_index", res_if.byte_index, want.byte_index);
        if (res_if.frame_end !== want.frame_end)
          report_mismatch("frame_end", {7'd0, res_if.frame_end}, {7'd0, want.frame_end});
        if (res_if.frame_good !== want.frame_good)
          report_mismatch("frame_good", {7'd0, res_if.frame_good}, {7'd0, want.frame_good});
      end
    end
  end

  // watchdog on cycles where no item moves on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles", StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts plus an occasional long hold
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else if (stall_left != 0) begin
      res_if.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      res_if.ready = 1'b0;
      stall_left   = $urandom_range(0, 13);
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // offer one received byte, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic clr);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = b;
    rx_if.restart = clr;
    do @(posedge clk); while (!rx_if.ready);
    deframe_byte(b, clr);
    sent_count++;
    @(negedge clk);
    rx_if.valid = 1'b0;
  endtask

  task automatic send_bytes(input logic [7:0] seq [$], input bit clr_first);
    foreach (seq[k]) send_byte(seq[k], clr_first && k == 0);
  endtask

  // build a frame with random payload; keep limits how many bytes go out
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input bit good,
                            input bit clr_first, input int unsigned keep);
    logic [7:0] frame_bytes [$];
    logic [7:0] chk;
    logic [7:0] pb;
    frame_bytes = {slcd_pkg::SyncFirst, slcd_pkg::SyncSecond, cmd, len, ~len};
    chk = cmd + len + ~len;
    repeat (len) begin
      pb = 8'($urandom);
      frame_bytes.push_back(pb);
      chk = chk + pb;
    end
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    frame_bytes.push_back(chk);
    foreach (frame_bytes[k]) begin
      if (k < keep) send_byte(frame_bytes[k], clr_first && k == 0);
    end
  endtask

  // mostly short payloads, a few long ones
  function automatic logic [7:0] random_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return 8'($urandom_range(0, 6));
    if (r < 19) return 8'($urandom_range(7, 32));
    return 8'($urandom_range(33, 254));
  endfunction

  task automatic send_random_chunk();
    int unsigned pick;
    logic [7:0]  seq [$];
    logic [7:0]  len;
    pick = $urandom_range(0, 99);
    len  = random_len();
    if (pick < 70) begin
      send_frame(8'($urandom), len, $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0,
                 WholeFrame);
    end else if (pick < 80) begin
      // line noise, biased toward the first sync byte
      repeat ($urandom_range(1, 6)) begin
        send_byte(($urandom_range(0, 2) == 0) ? slcd_pkg::SyncFirst : 8'($urandom),
                  $urandom_range(0, 15) == 0);
      end
    end else if (pick < 88) begin
      // header with a corrupted length complement
      seq = {slcd_pkg::SyncFirst, slcd_pkg::SyncSecond, 8'($urandom), len,
             ~len ^ 8'($urandom_range(1, 255))};
      send_bytes(seq, 1'b0);
    end else if (pick < 95) begin
      // frame cut short, next frame opens with a restart
      send_frame(8'($urandom), len, 1'b1, 1'b0, $urandom_range(1, len + 5));
      send_frame(8'($urandom), random_len(), 1'b1, 1'b1, WholeFrame);
    end else begin
      // stray sync bytes ahead of a real header
      if ($urandom_range(0, 1) != 0) seq = {slcd_pkg::SyncFirst};
      else seq = {slcd_pkg::SyncFirst, slcd_pkg::SyncSecond, slcd_pkg::SyncFirst};
      send_bytes(seq, 1'b0);
      send_frame(8'($urandom), len, $urandom_range(0, 3) != 0, 1'b0, WholeFrame);
    end
  endtask

  // sender holds back until every pending result has been taken
  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    logic [7:0] seq [$];
    idle_on = 1'b0;
    // empty payload, good checksum, restart on the first byte
    seq = {slcd_pkg::SyncFirst, slcd_pkg::SyncSecond, 8'h00, 8'h00, 8'hFF, 8'hFF};
    send_bytes(seq, 1'b1);
    // bad second sync, bad length complement with rescan, then a one-byte
    // frame with a bad checksum
    seq = {slcd_pkg::SyncFirst, 8'h00, slcd_pkg::SyncSecond, slcd_pkg::SyncFirst,
           slcd_pkg::SyncSecond, slcd_pkg::SyncFirst, slcd_pkg::SyncSecond,
           8'hFF, 8'h01, 8'hFE, 8'h00, 8'h12};
    send_bytes(seq, 1'b0);
    // restart in the middle of a payload drops the frame silently
    seq = {slcd_pkg::SyncFirst, slcd_pkg::SyncSecond, 8'h01, 8'h03, 8'hFC, 8'h11};
    send_bytes(seq, 1'b0);
    seq = {slcd_pkg::SyncFirst, slcd_pkg::SyncSecond, 8'h80, 8'h02, 8'hFD, 8'hFF, 8'h7F,
           8'hFD};
    send_bytes(seq, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    for (int round = 0; round < 6; round++) begin
      idle_on = (round != 2);
      // longest possible payload, once good and once bad
      if (round == 1 || round == 4)
        send_frame(8'($urandom), 8'hFF, round == 1, 1'b0, WholeFrame);
      while (sent_count < 40 + (round + 1) * 135) send_random_chunk();
      wait_results_drained();
    end
  endtask

  task automatic test_output_hold();
    idle_on      = 1'b0;
    hold_request = HoldCycles;
    send_frame(8'($urandom), 8'd24, 1'b1, 1'b0, WholeFrame);
    wait_results_drained();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    while (sent_count < TotalBytes)
      send_frame(8'($urandom), random_len(), $urandom_range(0, 3) != 0, 1'b0, WholeFrame);
  endtask

  initial begin
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    rx_if.restart = 1'b0;
    res_if.ready  = 1'b0;
    clear_deframer();
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic();
    test_output_hold();
    test_steady_stream();

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
